// ===== hw/rtl/tplnf_pkg.sv =====
// Shared types and widths for the two-point line normal form pipeline.
`default_nettype none
package tplnf_pkg;

   localparam int CoordW = 16;
   localparam int SqW    = 32;
   localparam int SumW   = 33;
   localparam int RhsW   = 64;
   localparam int AccW   = 70;
   localparam int MagW   = 16;
   localparam int Steps  = 16;
   localparam int OffW   = 17;

   typedef struct packed {
      logic                     zero;
      logic                     dx_neg;
      logic                     dy_pos;
      logic signed [CoordW-1:0] x2;
      logic signed [CoordW-1:0] y2;
   } ctx_type;

   // One axis of the bitwise search: p = k^2*s, g = k*s, with k = 2q-1.
   typedef struct packed {
      logic signed [AccW-1:0] p;
      logic signed [AccW-1:0] g;
      logic [RhsW-1:0]        rhs;
      logic [MagW-1:0]        q;
   } axis_type;

   typedef struct packed {
      logic [SumW-1:0] s;
      axis_type        ax_a;
      axis_type        ax_b;
      ctx_type         ctx;
   } stage_type;

endpackage
`default_nettype wire

// ===== hw/rtl/tplnf_front.sv =====
// Front end: differences, magnitudes, squares and search seed.
`default_nettype none
module tplnf_front
   import tplnf_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     en,
   input  wire logic                     in_valid,
   input  wire logic signed [CoordW-1:0] x1,
   input  wire logic signed [CoordW-1:0] y1,
   input  wire logic signed [CoordW-1:0] x2,
   input  wire logic signed [CoordW-1:0] y2,
   output logic                          out_valid,
   output stage_type                     out_stage
);

   logic signed [CoordW:0] dx, dy;
   logic [CoordW-1:0]      adx_in, ady_in, adx_ff, ady_ff;
   ctx_type                ctx1_in, ctx1_ff, ctx2_ff, ctx3_ff;
   logic [SqW-1:0]         sqx_ff, sqy_ff;
   logic                   v1_ff, v2_ff, v3_ff;
   logic [SumW-1:0]        s_ff;
   logic [RhsW-1:0]        ra_ff, rb_ff;

   always_comb begin
      logic signed [CoordW:0] ndx, ndy;
      dx  = {x2[CoordW-1], x2} - {x1[CoordW-1], x1};
      dy  = {y2[CoordW-1], y2} - {y1[CoordW-1], y1};
      ndx = -dx;
      ndy = -dy;
      adx_in = dx[CoordW] ? ndx[CoordW-1:0] : dx[CoordW-1:0];
      ady_in = dy[CoordW] ? ndy[CoordW-1:0] : dy[CoordW-1:0];
      ctx1_in.zero   = (dx == '0) && (dy == '0);
      ctx1_in.dx_neg = dx[CoordW];
      ctx1_in.dy_pos = !dy[CoordW] && (dy != '0);
      ctx1_in.x2     = x2;
      ctx1_in.y2     = y2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         adx_ff  <= adx_in;
         ady_ff  <= ady_in;
         ctx1_ff <= ctx1_in;
         sqx_ff  <= adx_ff * adx_ff;
         sqy_ff  <= ady_ff * ady_ff;
         ctx2_ff <= ctx1_ff;
         s_ff    <= {1'b0, sqx_ff} + {1'b0, sqy_ff};
         ra_ff   <= {sqy_ff, 32'd0};
         rb_ff   <= {sqx_ff, 32'd0};
         ctx3_ff <= ctx2_ff;
      end
   end

   // Seed with q = 0, i.e. k = -1: p = s, g = -s.
   always_comb begin
      logic signed [AccW-1:0] sw;
      sw = $signed({{(AccW-SumW){1'b0}}, s_ff});
      out_stage.s          = s_ff;
      out_stage.ax_a.p     = sw;
      out_stage.ax_a.g     = -sw;
      out_stage.ax_a.rhs   = ra_ff;
      out_stage.ax_a.q     = '0;
      out_stage.ax_b.p     = sw;
      out_stage.ax_b.g     = -sw;
      out_stage.ax_b.rhs   = rb_ff;
      out_stage.ax_b.q     = '0;
      out_stage.ctx        = ctx3_ff;
   end

   assign out_valid = v3_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/tplnf_root_step.sv =====
// One bit of the rounded unit-length search, both axes, registered.
`default_nettype none
module tplnf_root_step
   import tplnf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       en,
   input  wire logic [3:0] bit_idx,
   input  wire logic       in_valid,
   input  wire stage_type  in_stage,
   output logic            out_valid,
   output stage_type       out_stage
);

   stage_type stage_in, stage_ff;
   logic      valid_ff;

   function automatic axis_type trial(axis_type ax, logic [SumW-1:0] s, logic [3:0] j);
      logic signed [AccW-1:0] sw, pt;
      logic [5:0]             sh1, sh2;
      axis_type               res;
      sw  = $signed({{(AccW-SumW){1'b0}}, s});
      sh1 = {2'b00, j} + 6'd1;
      sh2 = {1'b0, j, 1'b0} + 6'd2;
      pt  = ax.p + (ax.g <<< (sh1 + 6'd1)) + (sw <<< sh2);
      res = ax;
      // (2t-1)^2 * s <= 4 m^2 2^30 keeps the bit; nothing beyond q = 0x8000
      if (!ax.q[MagW-1] && (pt <= $signed({{(AccW-RhsW){1'b0}}, ax.rhs}))) begin
         res.p = pt;
         res.g = ax.g + (sw <<< sh1);
         res.q = ax.q | (MagW'(1) << j);
      end
      return res;
   endfunction

   always_comb begin
      stage_in      = in_stage;
      stage_in.ax_a = trial(in_stage.ax_a, in_stage.s, bit_idx);
      stage_in.ax_b = trial(in_stage.ax_b, in_stage.s, bit_idx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/tplnf_back.sv =====
// Back end: signs, offset products, rounding, saturation, output register.
`default_nettype none
module tplnf_back
   import tplnf_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic                   in_valid,
   input  wire stage_type              in_stage,
   output logic                        out_valid,
   output logic signed [MagW-1:0]      normal_a,
   output logic signed [MagW-1:0]      normal_b,
   output logic signed [OffW-1:0]      offset_c,
   output logic                        valid_res
);

   logic signed [MagW-1:0]   a_in, b_in, a1_ff, b1_ff, a2_ff, b2_ff, a3_ff, b3_ff;
   ctx_type                  ctx1_ff, ctx2_ff, ctx3_ff;
   logic signed [2*CoordW-1:0] pa_ff, pb_ff;
   logic signed [2*CoordW:0] p_ff;
   logic signed [OffW-1:0]   c_in, c_ff;
   logic                     v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [MagW-1:0]   a_ff, b_ff;
   logic                     vr_ff;

   function automatic logic signed [MagW-1:0] apply_sign(logic [MagW-1:0] q, logic neg);
      logic signed [MagW-1:0] r;
      if (neg) r = -$signed(q);
      else if (q[MagW-1]) r = 16'sh7FFF;
      else r = $signed(q);
      return r;
   endfunction

   assign a_in = apply_sign(in_stage.ax_a.q, in_stage.ctx.dy_pos);
   assign b_in = apply_sign(in_stage.ax_b.q, in_stage.ctx.dx_neg);

   always_comb begin
      logic [2*CoordW:0]   pm;
      logic [2*CoordW-14:0] r;
      pm = p_ff[2*CoordW] ? 33'(-p_ff) : 33'(p_ff);
      r  = 19'((34'(pm) + 34'd16384) >> 15);
      if (ctx3_ff.zero) c_in = '0;
      else if (p_ff[2*CoordW])
         c_in = (r > 19'd65536) ? $signed(17'h10000) : -$signed(r[OffW-1:0]);
      else c_in = (r > 19'd65535) ? 17'sd65535 : $signed(r[OffW-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff   <= a_in;
         b1_ff   <= b_in;
         ctx1_ff <= in_stage.ctx;
         pa_ff   <= a1_ff * ctx1_ff.x2;
         pb_ff   <= b1_ff * ctx1_ff.y2;
         a2_ff   <= a1_ff;
         b2_ff   <= b1_ff;
         ctx2_ff <= ctx1_ff;
         p_ff    <= -({pa_ff[2*CoordW-1], pa_ff} + {pb_ff[2*CoordW-1], pb_ff});
         a3_ff   <= a2_ff;
         b3_ff   <= b2_ff;
         ctx3_ff <= ctx2_ff;
         c_ff    <= c_in;
         a_ff    <= ctx3_ff.zero ? '0 : a3_ff;
         b_ff    <= ctx3_ff.zero ? '0 : b3_ff;
         vr_ff   <= !ctx3_ff.zero;
      end
   end

   assign out_valid = v4_ff;
   assign normal_a  = a_ff;
   assign normal_b  = b_ff;
   assign offset_c  = c_ff;
   assign valid_res = vr_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/two_point_line_normal_form.sv =====
// Order from req transfer to rsp_valid: front end, 16-stage bitwise search, back end.
// Throughput: one transfer per cycle while not stalled; the search sets the depth.
// The whole pipeline holds while rsp_valid is high and rsp_ready is low.
// Reset (synchronous, active high) clears all valid bits; data registers are not reset.
`default_nettype none
module two_point_line_normal_form
   import tplnf_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic signed [CoordW-1:0] req_first_x,
   input  wire logic signed [CoordW-1:0] req_first_y,
   input  wire logic signed [CoordW-1:0] req_second_x,
   input  wire logic signed [CoordW-1:0] req_second_y,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [MagW-1:0]        rsp_normal_a,
   output logic signed [MagW-1:0]        rsp_normal_b,
   output logic signed [OffW-1:0]        rsp_offset_c,
   output logic                          rsp_valid_res
);

   logic      en;
   logic      sv [Steps+1];
   stage_type st [Steps+1];

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   tplnf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .x1        (req_first_x),
      .y1        (req_first_y),
      .x2        (req_second_x),
      .y2        (req_second_y),
      .out_valid (sv[0]),
      .out_stage (st[0])
   );

   for (genvar i = 0; i < Steps; i++) begin : g_step
      tplnf_root_step u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .bit_idx   (4'(Steps - 1 - i)),
         .in_valid  (sv[i]),
         .in_stage  (st[i]),
         .out_valid (sv[i+1]),
         .out_stage (st[i+1])
      );
   end

   tplnf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sv[Steps]),
      .in_stage  (st[Steps]),
      .out_valid (rsp_valid),
      .normal_a  (rsp_normal_a),
      .normal_b  (rsp_normal_b),
      .offset_c  (rsp_offset_c),
      .valid_res (rsp_valid_res)
   );

endmodule
`default_nettype wire

// ===== tb/two_point_line_normal_form_test.sv =====
// Testbench for the two-point line normal form pipeline: directed table plus random pairs.
`timescale 1ns / 100ps
`default_nettype none
module two_point_line_normal_form_test;
   import tplnf_pkg::*;

   localparam int Latency    = 23;
   localparam int WatchLimit = 20000;
   localparam int RandItems  = 600;
   localparam int HoldCycles = 200;

   typedef struct packed {
      logic signed [CoordW-1:0] x1;
      logic signed [CoordW-1:0] y1;
      logic signed [CoordW-1:0] x2;
      logic signed [CoordW-1:0] y2;
   } pair_type;

   typedef struct packed {
      logic signed [MagW-1:0] a;
      logic signed [MagW-1:0] b;
      logic signed [OffW-1:0] c;
      logic                   ok;
   } line_type;

   typedef struct {
      pair_type pt;
      bit       fixed;
      line_type want;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [CoordW-1:0] req_first_x = '0, req_first_y = '0;
   logic signed [CoordW-1:0] req_second_x = '0, req_second_y = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [MagW-1:0] rsp_normal_a, rsp_normal_b;
   logic signed [OffW-1:0] rsp_offset_c;
   logic rsp_valid_res;

   two_point_line_normal_form dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   line_type expected_lines[$];
   int    mismatches = 0;
   int    lines_seen = 0;
   int    degenerate_seen = 0;
   int    sat_seen = 0;
   bit    send_done = 0;
   bit    hold_off = 0;
   int    idle_cycles = 0;

   // |m| * 2^15 / sqrt(s), nearest with ties away, by bitwise search
   function automatic logic [16:0] unit_norm(longint unsigned m, longint unsigned s);
      longint unsigned rhs, k;
      logic [16:0] q, t;
      rhs = (m * m) << 32;
      q = 0;
      for (int i = 15; i >= 0; i--) begin
         t = q | (17'd1 << i);
         if (t <= 17'h8000) begin
            k = 2 * longint'(t) - 1;
            if (s <= rhs / (k * k)) q = t;
         end
      end
      return q;
   endfunction

   function automatic line_type hesse_line(pair_type pt);
      line_type r;
      longint dx, dy, av, bv, p, pm, rr, c;
      longint unsigned adx, ady, s;
      dx = longint'(pt.x2) - longint'(pt.x1);
      dy = longint'(pt.y2) - longint'(pt.y1);
      if (dx == 0 && dy == 0) return '0;
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      s = adx * adx + ady * ady;
      av = longint'(unit_norm(ady, s));
      if (dy > 0) av = -av;
      bv = longint'(unit_norm(adx, s));
      if (dx < 0) bv = -bv;
      if (av > 32767) av = 32767;
      if (bv > 32767) bv = 32767;
      p = -(av * longint'(pt.x2) + bv * longint'(pt.y2));
      pm = p < 0 ? -p : p;
      rr = (pm + 16384) >>> 15;
      c = p < 0 ? -rr : rr;
      if (c > 65535) c = 65535;
      if (c < -65536) c = -65536;
      r.a = av[15:0];
      r.b = bv[15:0];
      r.c = c[16:0];
      r.ok = 1'b1;
      return r;
   endfunction

   function automatic int gap_len();
      int g;
      g = $urandom_range(0, 99);
      if (g < 50) return 0;
      if (g < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic logic signed [15:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         default: return $signed(16'($urandom_range(0, 2000))) - 16'sd1000;
      endcase
   endfunction

   row_type rows[$];

   task automatic add_row(pair_type pt, bit fixed = 0, line_type want = '0);
      row_type r;
      r.pt = pt;
      r.fixed = fixed;
      r.want = want;
      rows.insert(rows.size(), r);
   endtask

   task automatic send_pair(pair_type pt, line_type want, bit fixed);
      req_valid <= 1;
      req_first_x <= pt.x1;
      req_first_y <= pt.y1;
      req_second_x <= pt.x2;
      req_second_y <= pt.y2;
      expected_lines.insert(expected_lines.size(), fixed ? want : hesse_line(pt));
      do @(posedge clock); while (!req_ready);
   endtask

   // sender
   initial begin
      pair_type pt;
      int g;
      // degenerate, extremes, axis-aligned, saturation
      add_row('{16'sd5, 16'sd5, 16'sd5, 16'sd5}, 1, '0);
      add_row('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 1, '0);
      add_row('{16'sd0, 16'sd0, 16'sd16, 16'sd0}, 1, '{16'sd0, 16'sd32767, 17'sd0, 1'b1});
      add_row('{16'sd0, 16'sd0, 16'sd0, 16'sd16}, 1, '{16'sh8000, 16'sd0, 17'sd0, 1'b1});
      add_row('{16'sd0, 16'sd0, -16'sd16, 16'sd0}, 1, '{16'sd0, 16'sh8000, 17'sd0, 1'b1});
      add_row('{16'sd0, 16'sd0, 16'sd0, -16'sd16}, 1, '{16'sd32767, 16'sd0, 17'sd0, 1'b1});
      add_row('{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff});
      add_row('{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000});
      add_row('{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000});
      add_row('{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff});
      add_row('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff});
      add_row('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff});
      add_row('{16'sd0, 16'sd0, 16'sd1, 16'sd1});
      add_row('{16'sd1, -16'sd1, -16'sd1, 16'sd1});
      add_row('{16'sd0, 16'sd0, 16'sd3, 16'sd4});
      add_row('{16'sd100, 16'sd200, -16'sd300, 16'sd50});
      add_row('{16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555});
      add_row('{16'sh8000, 16'sd0, 16'sh8001, 16'sh7fff});
      add_row('{16'sd0, 16'sh8000, 16'sd1, 16'sh8000});
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (rows[i]) send_pair(rows[i].pt, rows[i].want, rows[i].fixed);
      for (int n = 0; n < RandItems; n++) begin
         g = gap_len();
         if (g > 0) begin
            req_valid <= 0;
            repeat (g) @(posedge clock);
         end
         pt = {rand_coord(), rand_coord(), rand_coord(), rand_coord()};
         if ($urandom_range(0, 19) == 0) pt.x2 = pt.x1;
         if ($urandom_range(0, 19) == 0) pt.y2 = pt.y1;
         send_pair(pt, '0, 0);
      end
      req_valid <= 0;
      send_done = 1;
   end

   // receiver, with one long hold-off while the sender keeps going
   initial begin
      int g;
      @(negedge reset);
      repeat (40) @(posedge clock);
      hold_off = 1;
      rsp_ready <= 0;
      for (int i = 0; i < HoldCycles; i++) @(posedge clock);
      hold_off = 0;
      forever begin
         g = gap_len();
         if (g > 0) begin
            rsp_ready <= 0;
            repeat (g) @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
      end
   end

   // checker
   always @(posedge clock) begin
      line_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_normal_a, rsp_normal_b, rsp_offset_c, rsp_valid_res};
         lines_seen++;
         if (!rsp_valid_res) degenerate_seen++;
         if (rsp_offset_c == 17'sh0ffff || rsp_offset_c == 17'sh10000) sat_seen++;
         if (expected_lines.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transfer: a=%0d b=%0d c=%0d v=%0b",
               got.a, got.b, got.c, got.ok);
         end else begin
            want = expected_lines.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: want a=%0d b=%0d c=%0d v=%0b, got a=%0d b=%0d c=%0d v=%0b",
                     want.a, want.b, want.c, want.ok, got.a, got.b, got.c, got.ok);
            end
         end
      end
   end

   // watchdog: cycles with no transfer on either side
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || hold_off)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
         $display("watchdog expired, %0d lines outstanding", expected_lines.size());
         $display("two_point_line_normal_form_test: done, errors");
         $finish;
      end
   end

   initial begin
      wait (send_done);
      while (expected_lines.size() != 0) @(posedge clock);
      repeat (Latency + 10) @(posedge clock);
      if (expected_lines.size() != 0) mismatches++;
      $display("checked %0d lines (%0d coincident, %0d offsets at a limit), %0d mismatches",
         lines_seen, degenerate_seen, sat_seen, mismatches);
      if (mismatches == 0)
         $display("two_point_line_normal_form_test: done, clean");
      else
         $display("two_point_line_normal_form_test: done, errors");
      $finish;
   end

endmodule
`default_nettype wire
